FILE: hdl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types, constants and helper functions for the tone curve block.
// ----------------------------------------------------------------------------
package plc_pkg;

   localparam int KNOT_COUNT  = 10;
   localparam int CHANNELS    = 3;
   localparam int PIX_BITS    = 8;
   localparam int NUM_BITS    = 2 * PIX_BITS;
   localparam int QUO_BITS    = PIX_BITS;
   localparam int POS_BITS    = $clog2(QUO_BITS);
   localparam int CFG_BITS    = 40;
   localparam int CFG_COUNT   = 8;
   localparam int CFG_IDX_BITS = $clog2(CFG_COUNT);
   localparam int KNOT_BITS   = KNOT_COUNT * PIX_BITS;
   localparam int DATA_BITS   = CHANNELS * PIX_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CFG_IDX_BITS-1:0] {
      CFG_KNOT_LO,
      CFG_KNOT_HI,
      CFG_BLUE_LO,
      CFG_BLUE_HI,
      CFG_GREEN_LO,
      CFG_GREEN_HI,
      CFG_RED_LO,
      CFG_RED_HI
   } cfg_index_type;

   localparam logic [CFG_BITS-1:0] CFG_RESET [CFG_COUNT] = '{
      40'h7155381C00, 40'hFFE3C6AA8D,
      40'h8B68422600, 40'hFFF5E2CEAF,
      40'h8D62311800, 40'hFFEFDFC9AE,
      40'h7540231000, 40'hF9EDDEC8A3
   };

   typedef logic [KNOT_COUNT-1:0][PIX_BITS-1:0] knot_vec_type;
   typedef logic [CHANNELS-1:0][KNOT_COUNT-1:0][PIX_BITS-1:0] curve_set_type;

   // per-channel work for the back end: r = y0 + floor(num / dx), or y0 - ceil(num / dx) when neg
   typedef struct packed {
      logic [PIX_BITS-1:0] y0;
      logic                neg;
      logic [PIX_BITS-1:0] mag;
      logic [PIX_BITS-1:0] t;
      logic [PIX_BITS-1:0] dx;
   } chan_work_type;

   typedef chan_work_type [CHANNELS-1:0] item_work_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] y0;
      logic                neg;
      logic [PIX_BITS-1:0] dx;
      logic [NUM_BITS-1:0] rem;
      logic [QUO_BITS-1:0] quo;
   } div_type;

   typedef struct packed {
      logic nonempty;
      logic full;
   } q_status_type;

   // first knot with a <= x[k]; exact hits and ends map directly
   function automatic chan_work_type classify(logic [PIX_BITS-1:0] a, knot_vec_type x,
                                              knot_vec_type y);
      chan_work_type       w;
      logic                none_before;
      logic                le;
      logic [PIX_BITS:0]   dy;
      int                  km1;
      w.y0 = y[KNOT_COUNT-1];
      w.neg = 1'b0;
      w.mag = '0;
      w.t = '0;
      w.dx = PIX_BITS'(1);
      none_before = 1'b1;
      dy = '0;
      for (int k = 0; k < KNOT_COUNT; k++) begin
         km1 = (k == 0) ? 0 : k - 1;
         le = (a <= x[k]);
         if (le && none_before) begin
            if (k == 0 || a == x[k]) begin
               w.y0 = y[k];
            end else begin
               dy = {1'b0, y[k]} - {1'b0, y[km1]};
               w.y0 = y[km1];
               w.neg = dy[PIX_BITS];
               w.mag = dy[PIX_BITS] ? PIX_BITS'(-dy) : dy[PIX_BITS-1:0];
               w.t = a - x[km1];
               w.dx = x[k] - x[km1];
            end
         end
         none_before = none_before & ~le;
      end
      return w;
   endfunction

   // one restoring division step for quotient bit pos
   function automatic div_type div_step(div_type d, logic [POS_BITS-1:0] pos);
      div_type             r;
      logic [NUM_BITS-1:0] sub;
      r = d;
      sub = {{(NUM_BITS-PIX_BITS){1'b0}}, d.dx} << pos;
      if (d.rem >= sub) begin
         r.rem = d.rem - sub;
         r.quo[pos] = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: hdl/plc_front.sv
// ----------------------------------------------------------------------------
// plc_front
// Input stage: takes a pixel, finds each channel's segment, registers the work.
// ----------------------------------------------------------------------------
module plc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [plc_pkg::DATA_BITS-1:0] req_tdata,  // blue, green, red
   input  plc_pkg::knot_vec_type   knot_x,
   input  plc_pkg::curve_set_type  curve_y,
   input  plc_pkg::q_status_type   q_stat,
   output logic                    push,
   output plc_pkg::item_work_type  push_data
);
   import plc_pkg::*;

   logic          front_valid_ff, front_valid_in;
   item_work_type work_ff, work_in;
   logic          accept;

   assign push       = front_valid_ff & ~q_stat.full;
   assign req_tready = ~front_valid_ff | ~q_stat.full;
   assign accept     = req_tvalid & req_tready;
   assign push_data  = work_ff;

   always_comb begin
      front_valid_in = accept ? 1'b1 : (push ? 1'b0 : front_valid_ff);
      work_in = work_ff;
      if (accept) begin
         for (int c = 0; c < CHANNELS; c++) begin
            work_in[c] = classify(req_tdata[c*PIX_BITS +: PIX_BITS], knot_x, curve_y[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      work_ff <= work_in;
   end

endmodule

FILE: hdl/plc_queue.sv
// ----------------------------------------------------------------------------
// plc_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module plc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  plc_pkg::item_work_type push_data,
   input  logic                   pop,
   output plc_pkg::item_work_type pop_data,
   output plc_pkg::q_status_type  q_stat
);
   import plc_pkg::*;

   item_work_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_stat.nonempty = (count_ff != '0);
   assign q_stat.full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign do_push  = push & ~q_stat.full;
   assign do_pop   = pop & q_stat.nonempty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/plc_back.sv
// ----------------------------------------------------------------------------
// plc_back
// Execution pipe: multiply, bit-per-stage divide, offset and clamp, output reg.
// ----------------------------------------------------------------------------
module plc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  plc_pkg::q_status_type  q_stat,
   input  plc_pkg::item_work_type pop_data,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [plc_pkg::DATA_BITS-1:0] rsp_tdata  // blue, green, red
);
   import plc_pkg::*;

   localparam int STAGES = QUO_BITS + 1;

   div_type                 st_ff [STAGES][CHANNELS];
   div_type                 st_in [STAGES][CHANNELS];
   logic [STAGES-1:0]       valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic                    adv;
   logic [NUM_BITS-1:0]     prod;
   logic [PIX_BITS+1:0]     sum;
   div_type                 last;

   assign adv        = ~rsp_valid_ff | rsp_tready;
   assign pop        = adv & q_stat.nonempty;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      prod = '0;
      sum  = '0;
      last = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         // ceil for a falling segment: floor((n + dx - 1) / dx)
         prod = NUM_BITS'(pop_data[c].mag) * NUM_BITS'(pop_data[c].t);
         st_in[0][c].y0  = pop_data[c].y0;
         st_in[0][c].neg = pop_data[c].neg;
         st_in[0][c].dx  = pop_data[c].dx;
         st_in[0][c].rem = prod + (pop_data[c].neg ?
                           NUM_BITS'(pop_data[c].dx - 1'b1) : NUM_BITS'(0));
         st_in[0][c].quo = '0;
         for (int s = 0; s < STAGES - 1; s++) begin
            st_in[s+1][c] = div_step(st_ff[s][c], POS_BITS'(QUO_BITS - 1 - s));
         end
         last = st_ff[STAGES-1][c];
         sum = last.neg ? {2'b00, last.y0} - {2'b00, last.quo}
                        : {2'b00, last.y0} + {2'b00, last.quo};
         if (sum[PIX_BITS+1]) begin
            rsp_data_in[c*PIX_BITS +: PIX_BITS] = '0;
         end else if (sum[PIX_BITS]) begin
            rsp_data_in[c*PIX_BITS +: PIX_BITS] = '1;
         end else begin
            rsp_data_in[c*PIX_BITS +: PIX_BITS] = sum[PIX_BITS-1:0];
         end
      end
      valid_in     = {valid_ff[STAGES-2:0], q_stat.nonempty};
      rsp_valid_in = valid_ff[STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         st_ff       <= st_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: hdl/piecewise_linear_tone_curve.sv
// ----------------------------------------------------------------------------
// piecewise_linear_tone_curve
// Maps each channel of a blue/green/red pixel through its own tone curve.
// ----------------------------------------------------------------------------
// req_* carries one pixel per item (blue in tdata[7:0], green [15:8], red
// [23:16]); rsp_* returns the mapped pixel in the same layout, one result per
// item, in order. csr_* writes the eight 40-bit knot and curve registers; write
// them only while no item is in flight.
// Throughput is one pixel per clock while rsp_tready is high. From req accept to
// rsp_tvalid an item passes the input register, queue slot, multiply, eight divider
// stages (one quotient bit each) and the output register.
// Reset loads the default curves and empties the pipe. When rsp_tready is low
// with a result waiting, the back pipe holds; the two-entry queue and the input
// register keep taking items until both are full, then req_tready drops.
// ----------------------------------------------------------------------------
module piecewise_linear_tone_curve (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [plc_pkg::DATA_BITS-1:0]    req_tdata,   // in_blue, in_green, in_red
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [plc_pkg::DATA_BITS-1:0]    rsp_tdata,   // out_blue, out_green, out_red
   input  logic                             csr_we,
   input  logic [plc_pkg::CFG_IDX_BITS-1:0] csr_index,
   input  logic [plc_pkg::CFG_BITS-1:0]     csr_wdata
);
   import plc_pkg::*;

   logic [CFG_BITS-1:0]   cfg_ff [CFG_COUNT];
   logic [CFG_BITS-1:0]   cfg_in [CFG_COUNT];
   logic [2*CFG_BITS-1:0] knot_all;
   logic [2*CFG_BITS-1:0] curve_all [CHANNELS];
   knot_vec_type          knot_x;
   curve_set_type         curve_y;
   q_status_type          q_stat;
   logic                  push, pop;
   item_work_type         push_data, pop_data;

   always_comb begin
      for (int i = 0; i < CFG_COUNT; i++) begin
         cfg_in[i] = (csr_we && csr_index == CFG_IDX_BITS'(i)) ? csr_wdata : cfg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign knot_all = {cfg_ff[CFG_KNOT_HI], cfg_ff[CFG_KNOT_LO]};
   assign knot_x   = knot_all[KNOT_BITS-1:0];

   for (genvar c = 0; c < CHANNELS; c++) begin : g_curve
      assign curve_all[c] = {cfg_ff[CFG_BLUE_HI + 2*c], cfg_ff[CFG_BLUE_LO + 2*c]};
      assign curve_y[c]   = curve_all[c][KNOT_BITS-1:0];
   end

   plc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .knot_x     (knot_x),
      .curve_y    (curve_y),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   plc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   plc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_full_grows: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> $past(q_stat.nonempty))
      else $error("queue filled faster than one item per cycle");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.nonempty)
      else $error("back end popped an empty queue");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      q_stat.full && !pop |=> q_stat.full)
      else $error("full queue lost an item without a pop");

endmodule

FILE: test/piecewise_linear_tone_curve_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_tone_curve_tb
// Streams pixels through the tone curve block under a series of knot and
// curve settings and checks every mapped pixel against an in-bench model.
// Settings cover the defaults, falling curves, knots that leave the ends
// uncovered, all-zero and all-one registers, and random sorted and unsorted
// knots. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module piecewise_linear_tone_curve_tb;
   import plc_pkg::*;

   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;
   localparam int PHASE_ITEMS = 160;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
   } pixel_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DATA_BITS-1:0]    req_tdata = '0;   // in_blue, in_green, in_red
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]    rsp_tdata;        // out_blue, out_green, out_red
   logic                    csr_we = 1'b0;
   logic [CFG_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]     csr_wdata = '0;

   logic [CFG_BITS-1:0] cfg_regs [CFG_COUNT] = '{
      40'h7155381C00, 40'hFFE3C6AA8D,
      40'h8B68422600, 40'hFFF5E2CEAF,
      40'h8D62311800, 40'hFFEFDFC9AE,
      40'h7540231000, 40'hF9EDDEC8A3
   };

   pixel_type pixel_backlog [$];
   pixel_type expected_pixels [$];
   pixel_type seen_pixel;
   pixel_type due_pixel;
   int        sent_count = 0;
   int        mapped_count = 0;
   int        error_count = 0;
   int        send_gap = 0;
   int        send_quiet = 0;
   int        hold_left = 0;
   int        hold_quiet = 0;

   piecewise_linear_tone_curve dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int reg_byte(logic [CFG_BITS-1:0] lo, logic [CFG_BITS-1:0] hi, int k);
      logic [CFG_BITS-1:0] w;
      w = (k < 5) ? lo : hi;
      return int'(w[8 * (k % 5) +: 8]);
   endfunction

   function automatic int knot_at(int k);
      return reg_byte(cfg_regs[CFG_KNOT_LO], cfg_regs[CFG_KNOT_HI], k);
   endfunction

   // first knot with a <= x[j]; between knots: y0 + floor(dy * (a - x0) / dx)
   function automatic logic [PIX_BITS-1:0] tone_map(logic [PIX_BITS-1:0] a, int ch);
      int lo_idx, j, av, x0, x1, y0, y1, dx, num, q, r;
      bit found;
      lo_idx = int'(CFG_BLUE_LO) + 2 * ch;
      av = int'(a);
      found = 1'b0;
      j = KNOT_COUNT;
      for (int k = 0; k < KNOT_COUNT; k++) begin
         if (!found && av <= knot_at(k)) begin
            found = 1'b1;
            j = k;
         end
      end
      if (j == KNOT_COUNT) begin
         r = reg_byte(cfg_regs[lo_idx], cfg_regs[lo_idx + 1], KNOT_COUNT - 1);
      end else if (j == 0 || av == knot_at(j)) begin
         r = reg_byte(cfg_regs[lo_idx], cfg_regs[lo_idx + 1], j);
      end else begin
         x0 = knot_at(j - 1);
         x1 = knot_at(j);
         y0 = reg_byte(cfg_regs[lo_idx], cfg_regs[lo_idx + 1], j - 1);
         y1 = reg_byte(cfg_regs[lo_idx], cfg_regs[lo_idx + 1], j);
         dx = x1 - x0;
         num = (y1 - y0) * (av - x0);
         q = num / dx;
         if (num % dx != 0 && num < 0) q = q - 1;
         r = y0 + q;
      end
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      return PIX_BITS'(r);
   endfunction

   function automatic pixel_type map_pixel(pixel_type p);
      pixel_type m;
      m.blue  = tone_map(p.blue, CH_BLUE);
      m.green = tone_map(p.green, CH_GREEN);
      m.red   = tone_map(p.red, CH_RED);
      return m;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // near a knot a quarter of the time, else uniform
   function automatic logic [PIX_BITS-1:0] pick_level();
      logic [PIX_BITS-1:0] v;
      if ($urandom_range(0, 3) == 0) begin
         v = PIX_BITS'(knot_at($urandom_range(0, KNOT_COUNT - 1)));
         v = v + PIX_BITS'($urandom_range(0, 2)) - PIX_BITS'(1);
      end else begin
         v = PIX_BITS'($urandom_range(0, 255));
      end
      return v;
   endfunction

   function automatic knot_vec_type random_bytes();
      knot_vec_type kv;
      kv = KNOT_BITS'({$urandom, $urandom, $urandom});
      return kv;
   endfunction

   function automatic knot_vec_type sorted_knots();
      logic [255:0]  used;
      knot_vec_type  kv;
      int            n;
      used = '0;
      while ($countones(used) < KNOT_COUNT) used[$urandom_range(0, 255)] = 1'b1;
      n = 0;
      kv = '0;
      for (int v = 0; v < 256; v++) begin
         if (used[v]) begin
            kv[n] = PIX_BITS'(v);
            n++;
         end
      end
      return kv;
   endfunction

   task automatic flag_error(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic queue_pixel(logic [PIX_BITS-1:0] b, logic [PIX_BITS-1:0] g,
                              logic [PIX_BITS-1:0] r);
      pixel_type p;
      p.blue = b;
      p.green = g;
      p.red = r;
      pixel_backlog.push_back(p);
      sent_count++;
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) queue_pixel(pick_level(), pick_level(), pick_level());
   endtask

   task automatic write_reg(cfg_index_type idx, logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_regs[idx] = value;
   endtask

   task automatic write_curves(knot_vec_type kx, knot_vec_type yb, knot_vec_type yg,
                               knot_vec_type yr);
      write_reg(CFG_KNOT_LO, kx[4:0]);
      write_reg(CFG_KNOT_HI, kx[9:5]);
      write_reg(CFG_BLUE_LO, yb[4:0]);
      write_reg(CFG_BLUE_HI, yb[9:5]);
      write_reg(CFG_GREEN_LO, yg[4:0]);
      write_reg(CFG_GREEN_HI, yg[9:5]);
      write_reg(CFG_RED_LO, yr[4:0]);
      write_reg(CFG_RED_HI, yr[9:5]);
   endtask

   task automatic wait_idle();
      while (mapped_count != sent_count) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) expected_pixels.push_back(map_pixel(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 || pixel_backlog.size() == 0) begin
               req_tvalid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= pixel_backlog.pop_front();
               if (send_quiet > 0) begin
                  send_quiet--;
                  send_gap = 0;
               end else begin
                  send_gap = idle_length();
                  if ($urandom_range(0, 49) == 0) send_quiet = $urandom_range(40, 100);
               end
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_pixel = rsp_tdata;
            if (expected_pixels.size() == 0) begin
               flag_error($sformatf("pixel %06h with nothing pending", rsp_tdata));
            end else begin
               due_pixel = expected_pixels.pop_front();
               mapped_count++;
               if (seen_pixel.blue != due_pixel.blue)
                  flag_error($sformatf("blue %0d, expected %0d", seen_pixel.blue,
                                       due_pixel.blue));
               if (seen_pixel.green != due_pixel.green)
                  flag_error($sformatf("green %0d, expected %0d", seen_pixel.green,
                                       due_pixel.green));
               if (seen_pixel.red != due_pixel.red)
                  flag_error($sformatf("red %0d, expected %0d", seen_pixel.red,
                                       due_pixel.red));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (hold_quiet > 0) hold_quiet--;
            else if ($urandom_range(0, 3) == 0) hold_left = idle_length();
            else if ($urandom_range(0, 59) == 0) hold_quiet = $urandom_range(50, 150);
         end
      end
   end

   initial begin
      knot_vec_type kx, yb, yg, yr;
      knot_vec_type base_b, base_g, base_r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      kx = {cfg_regs[CFG_KNOT_HI], cfg_regs[CFG_KNOT_LO]};
      base_b = {cfg_regs[CFG_BLUE_HI], cfg_regs[CFG_BLUE_LO]};
      base_g = {cfg_regs[CFG_GREEN_HI], cfg_regs[CFG_GREEN_LO]};
      base_r = {cfg_regs[CFG_RED_HI], cfg_regs[CFG_RED_LO]};

      // default curves: on each knot and just beside it
      for (int k = 0; k < KNOT_COUNT; k++)
         queue_pixel(kx[k], kx[k] + PIX_BITS'(1), kx[k] - PIX_BITS'(1));
      queue_pixel(8'd0, 8'd255, 8'd128);
      queue_pixel(8'd255, 8'd0, 8'd1);
      queue_pixel(8'd127, 8'd200, 8'd254);
      queue_random(150);

      for (int p = 0; p < 10; p++) begin
         wait_idle();
         case (p)
            0: begin
               // falling curves
               yb = ~base_b;
               yg = ~base_g;
               yr = ~base_r;
            end
            1: begin
               // first knot above zero, last below full scale
               kx = 80'hC8_B4_A0_8C_78_64_50_3C_28_14;
               yb = random_bytes();
               yg = random_bytes();
               yr = random_bytes();
            end
            2: begin
               kx = '0;
               yb = '1;
               yg = '1;
               yr = '1;
            end
            3: begin
               kx = '1;
               yb = random_bytes();
               yg = '0;
               yr = random_bytes();
            end
            4: begin
               // tight knots then one wide final segment, full-swing outputs
               kx = 80'hFF_08_07_06_05_04_03_02_01_00;
               yb = 80'hFF_00_FF_00_FF_00_FF_00_FF_00;
               yg = 80'h00_FF_00_FF_00_FF_00_FF_00_FF;
               yr = random_bytes();
            end
            7, 9: begin
               kx = random_bytes();
               yb = random_bytes();
               yg = random_bytes();
               yr = random_bytes();
            end
            default: begin
               kx = sorted_knots();
               yb = random_bytes();
               yg = random_bytes();
               yr = random_bytes();
            end
         endcase
         write_curves(kx, yb, yg, yr);
         if (p == 1) begin
            queue_pixel(8'd0, 8'd255, 8'd19);
            queue_pixel(8'd255, 8'd0, 8'd201);
            queue_pixel(8'd20, 8'd200, 8'd21);
            queue_pixel(8'd199, 8'd1, 8'd254);
         end
         queue_random(PHASE_ITEMS);
      end

      wait_idle();
      if (expected_pixels.size() != 0)
         flag_error($sformatf("%0d pixels never returned", expected_pixels.size()));
      if (error_count == 0) begin
         $display("piecewise_linear_tone_curve_tb OK");
      end else begin
         $display("piecewise_linear_tone_curve_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("piecewise_linear_tone_curve_tb NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/plc_pkg.sv
hdl/plc_front.sv
hdl/plc_queue.sv
hdl/plc_back.sv
hdl/piecewise_linear_tone_curve.sv
test/piecewise_linear_tone_curve_tb.sv
